// File: hw/rtl/eoq_pkg.sv
`timescale 1ns / 1ps

package eoq_pkg;

    // Operation codes carried by a request.
    typedef enum logic [2:0] {
        OP_ADD_PICK  = 3'd0,
        OP_ADD_DROP  = 3'd1,
        OP_OLDEST    = 3'd2,
        OP_SET_DROP  = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_FIND_PICK = 3'd6,
        OP_FIND_DROP = 3'd7
    } t_opcode;

    // Status codes returned with every result.
    typedef enum logic [2:0] {
        STAT_DONE = 3'd0,
        STAT_DUP  = 3'd1,
        STAT_NONE = 3'd2,
        STAT_FULL = 3'd3,
        STAT_BADH = 3'd4
    } t_status;

    // Direction that stands for "no direction".
    localparam logic [1:0] DIR_NONE = 2'd2;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_HCHK,
        S_CLAIM,
        S_LINK,
        S_OUT
    } t_state;

endpackage

// File: hw/rtl/eoq_entry_ram.sv
`timescale 1ns / 1ps

module eoq_entry_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/elevator_order_queue_core.sv
`timescale 1ns / 1ps

// Elevator order table. Orders live in MAX_ORDERS slots of an entry RAM and are
// linked newest first; a request is taken only while the core is idle and it
// is answered by exactly one result. Adds and finds walk the list at one linked
// entry per cycle, because the next link read from the RAM addresses the next
// read directly. Get oldest walks the whole list, remove walks only when the
// order is not the newest, and set drop-off links in a copy when the order
// already has a drop-off. Clear and rejected handles need no walk. A finished
// result sits in an output register, so the next request is taken while it
// waits to be read.
module elevator_order_queue_core #(
    parameter int MAX_ORDERS = 16,
    parameter int NUM_FLOORS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_floor,
    input  logic [1:0] i_travel_dir,
    input  logic [3:0] i_handle,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic       o_found,
    output logic [4:0] o_result_handle,
    output logic [2:0] o_res_pickup,
    output logic [1:0] o_res_dir,
    output logic [2:0] o_res_dropoff
);

    localparam int IW = $clog2(MAX_ORDERS);
    localparam int SW = $clog2(MAX_ORDERS + 1);
    localparam int FW = $clog2(NUM_FLOORS + 1);
    localparam logic [SW-1:0] NO_SLOT = SW'(MAX_ORDERS);
    localparam logic [FW-1:0] NO_FLOOR = FW'(NUM_FLOORS);

    typedef struct packed {
        logic [FW-1:0] pick;
        logic [1:0]    dir;
        logic [FW-1:0] drop;
        logic [SW-1:0] next;
    } t_entry;

    typedef struct packed {
        eoq_pkg::t_status status;
        logic [SW-1:0]    slot;
        logic [FW-1:0]    pick;
        logic [1:0]       dir;
        logic [FW-1:0]    drop;
    } t_result;

    localparam int EW = $bits(t_entry);

    // Lowest slot that is not in use.
    function automatic logic [IW-1:0] lowest_free(input logic [MAX_ORDERS-1:0] used);
        logic [IW-1:0] res;
        res = '0;
        for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                res = IW'(i);
            end
        end
        return res;
    endfunction

    function automatic t_result res_order(input eoq_pkg::t_status st,
                                          input logic [SW-1:0] slot,
                                          input t_entry e);
        t_result r;
        r.status = st;
        r.slot   = slot;
        r.pick   = e.pick;
        r.dir    = e.dir;
        r.drop   = e.drop;
        return r;
    endfunction

    function automatic t_result res_none(input eoq_pkg::t_status st);
        t_result r;
        r.status = st;
        r.slot   = NO_SLOT;
        r.pick   = '0;
        r.dir    = '0;
        r.drop   = '0;
        return r;
    endfunction

    eoq_pkg::t_state  r_state, n_state;
    eoq_pkg::t_opcode r_op, n_op;
    logic [FW-1:0]    r_fl, n_fl;
    logic [1:0]       r_dir, n_dir;
    logic [SW-1:0]    r_h, n_h;
    logic [SW-1:0]    r_cur, n_cur;
    t_entry           r_hent, n_hent;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_count, n_count;
    logic [MAX_ORDERS-1:0] r_in_use, n_in_use;
    t_result          r_res, n_res;

    logic             r_o_valid, n_o_valid;
    logic [2:0]       r_o_status;
    logic             r_o_found;
    logic [4:0]       r_o_handle;
    logic [2:0]       r_o_pick;
    logic [1:0]       r_o_dir;
    logic [2:0]       r_o_drop;

    logic             ram_we;
    logic [IW-1:0]    ram_wa;
    t_entry           ram_wd;
    logic [IW-1:0]    ram_ra;
    logic [EW-1:0]    ram_q;
    t_entry           mem_q;

    logic             accept;
    logic             out_free;
    logic [FW-1:0]    fl_in;
    logic [1:0]       dir_in;
    logic             h_bad;
    logic             list_empty;
    logic             table_full;
    logic [IW-1:0]    free_idx;
    logic             walk_hit;
    logic             walk_last;
    logic             is_add;
    t_entry           claim_ent;

    eoq_entry_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_ORDERS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_q)
    );

    assign mem_q = t_entry'(ram_q);

    // Request decode and normalization of the operands.
    assign accept     = i_in_valid && (r_state == eoq_pkg::S_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign fl_in      = (32'(i_floor) >= NUM_FLOORS) ? NO_FLOOR : FW'(i_floor);
    assign dir_in     = (i_travel_dir > eoq_pkg::DIR_NONE) ? eoq_pkg::DIR_NONE : i_travel_dir;
    assign h_bad      = (32'(i_handle) >= MAX_ORDERS) || !r_in_use[IW'(i_handle)];
    assign list_empty = (r_head == NO_SLOT);
    assign table_full = (r_count == NO_SLOT);
    assign free_idx   = lowest_free(r_in_use);
    assign is_add     = (r_op == eoq_pkg::OP_ADD_PICK) || (r_op == eoq_pkg::OP_ADD_DROP);
    assign walk_last  = (mem_q.next == NO_SLOT);

    // Match test on the entry that the walk currently holds.
    always_comb begin
        case (r_op)
            eoq_pkg::OP_ADD_PICK,
            eoq_pkg::OP_FIND_PICK: walk_hit = (mem_q.pick == r_fl) && (mem_q.dir == r_dir);
            eoq_pkg::OP_ADD_DROP,
            eoq_pkg::OP_FIND_DROP: walk_hit = (mem_q.drop == r_fl);
            eoq_pkg::OP_REMOVE:    walk_hit = (mem_q.next == r_h);
            default:               walk_hit = 1'b0;
        endcase
    end

    // Entry written when a new slot is claimed.
    always_comb begin
        case (r_op)
            eoq_pkg::OP_SET_DROP: claim_ent = '{r_hent.pick, r_hent.dir, r_fl, r_hent.next};
            eoq_pkg::OP_ADD_DROP: claim_ent = '{NO_FLOOR, eoq_pkg::DIR_NONE, r_fl, r_head};
            default:              claim_ent = '{r_fl, r_dir, NO_FLOOR, r_head};
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            eoq_pkg::S_IDLE: begin
                if (accept) begin
                    case (eoq_pkg::t_opcode'(i_opcode))
                        eoq_pkg::OP_ADD_PICK,
                        eoq_pkg::OP_ADD_DROP: begin
                            n_state = list_empty ? eoq_pkg::S_CLAIM : eoq_pkg::S_WALK;
                        end
                        eoq_pkg::OP_OLDEST,
                        eoq_pkg::OP_FIND_PICK,
                        eoq_pkg::OP_FIND_DROP: begin
                            n_state = list_empty ? eoq_pkg::S_OUT : eoq_pkg::S_WALK;
                        end
                        eoq_pkg::OP_SET_DROP,
                        eoq_pkg::OP_REMOVE: begin
                            n_state = h_bad ? eoq_pkg::S_OUT : eoq_pkg::S_HCHK;
                        end
                        default: begin
                            n_state = eoq_pkg::S_OUT;
                        end
                    endcase
                end
            end
            eoq_pkg::S_WALK: begin
                if (walk_hit) begin
                    if ((r_op == eoq_pkg::OP_ADD_PICK) && (mem_q.drop != NO_FLOOR)) begin
                        n_state = eoq_pkg::S_CLAIM;
                    end else begin
                        n_state = eoq_pkg::S_OUT;
                    end
                end else if (walk_last) begin
                    n_state = is_add ? eoq_pkg::S_CLAIM : eoq_pkg::S_OUT;
                end
            end
            eoq_pkg::S_HCHK: begin
                if (r_op == eoq_pkg::OP_SET_DROP) begin
                    n_state = (mem_q.drop == NO_FLOOR) ? eoq_pkg::S_OUT : eoq_pkg::S_CLAIM;
                end else begin
                    n_state = (r_head == r_h) ? eoq_pkg::S_OUT : eoq_pkg::S_WALK;
                end
            end
            eoq_pkg::S_CLAIM: begin
                if (!table_full && (r_op == eoq_pkg::OP_SET_DROP)) begin
                    n_state = eoq_pkg::S_LINK;
                end else begin
                    n_state = eoq_pkg::S_OUT;
                end
            end
            eoq_pkg::S_LINK: begin
                n_state = eoq_pkg::S_OUT;
            end
            eoq_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = eoq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = eoq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM accesses and table bookkeeping.
    always_comb begin
        n_op      = r_op;
        n_fl      = r_fl;
        n_dir     = r_dir;
        n_h       = r_h;
        n_cur     = r_cur;
        n_hent    = r_hent;
        n_head    = r_head;
        n_count   = r_count;
        n_in_use  = r_in_use;
        n_res     = r_res;
        n_o_valid = r_o_valid && i_out_stall;
        ram_we    = 1'b0;
        ram_wa    = '0;
        ram_wd    = mem_q;
        ram_ra    = '0;
        case (r_state)
            eoq_pkg::S_IDLE: begin
                if (accept) begin
                    n_op  = eoq_pkg::t_opcode'(i_opcode);
                    n_fl  = fl_in;
                    n_dir = dir_in;
                    n_h   = SW'(i_handle);
                    case (eoq_pkg::t_opcode'(i_opcode))
                        eoq_pkg::OP_SET_DROP,
                        eoq_pkg::OP_REMOVE: begin
                            ram_ra = IW'(i_handle);
                            n_res  = res_none(eoq_pkg::STAT_BADH);
                        end
                        eoq_pkg::OP_CLEAR: begin
                            n_in_use = '0;
                            n_head   = NO_SLOT;
                            n_count  = '0;
                            n_res    = res_none(eoq_pkg::STAT_DONE);
                        end
                        default: begin
                            ram_ra = r_head[IW-1:0];
                            n_cur  = r_head;
                            n_res  = res_none(eoq_pkg::STAT_NONE);
                        end
                    endcase
                end
            end
            eoq_pkg::S_WALK: begin
                if (walk_hit || walk_last) begin
                    case (r_op)
                        eoq_pkg::OP_ADD_PICK: begin
                            if (walk_hit && (mem_q.drop == NO_FLOOR)) begin
                                n_res = res_order(eoq_pkg::STAT_DUP, r_cur, mem_q);
                            end
                        end
                        eoq_pkg::OP_ADD_DROP: begin
                            if (walk_hit) begin
                                n_res = res_order(eoq_pkg::STAT_DUP, r_cur, mem_q);
                            end
                        end
                        eoq_pkg::OP_OLDEST: begin
                            n_res = res_order(eoq_pkg::STAT_DONE, r_cur, mem_q);
                        end
                        eoq_pkg::OP_REMOVE: begin
                            // Unlink the order behind its predecessor and free it.
                            if (walk_hit) begin
                                ram_we = 1'b1;
                                ram_wa = r_cur[IW-1:0];
                                ram_wd = '{mem_q.pick, mem_q.dir, mem_q.drop, r_hent.next};
                            end
                            n_in_use[r_h[IW-1:0]] = 1'b0;
                            if (r_count != '0) begin
                                n_count = r_count - SW'(1);
                            end
                            n_res = res_none(eoq_pkg::STAT_DONE);
                        end
                        default: begin
                            if (walk_hit) begin
                                n_res = res_order(eoq_pkg::STAT_DONE, r_cur, mem_q);
                            end else begin
                                n_res = res_none(eoq_pkg::STAT_NONE);
                            end
                        end
                    endcase
                end else begin
                    ram_ra = mem_q.next[IW-1:0];
                    n_cur  = mem_q.next;
                end
            end
            eoq_pkg::S_HCHK: begin
                n_hent = mem_q;
                if (r_op == eoq_pkg::OP_SET_DROP) begin
                    if (mem_q.drop == NO_FLOOR) begin
                        ram_we = 1'b1;
                        ram_wa = r_h[IW-1:0];
                        ram_wd = '{mem_q.pick, mem_q.dir, r_fl, mem_q.next};
                        n_res  = res_order(eoq_pkg::STAT_DONE, r_h, ram_wd);
                    end
                end else if (r_head == r_h) begin
                    n_head                = mem_q.next;
                    n_in_use[r_h[IW-1:0]] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - SW'(1);
                    end
                    n_res = res_none(eoq_pkg::STAT_DONE);
                end else begin
                    ram_ra = r_head[IW-1:0];
                    n_cur  = r_head;
                end
            end
            eoq_pkg::S_CLAIM: begin
                if (table_full) begin
                    n_res = res_none(eoq_pkg::STAT_FULL);
                end else begin
                    ram_we             = 1'b1;
                    ram_wa             = free_idx;
                    ram_wd             = claim_ent;
                    n_in_use[free_idx] = 1'b1;
                    n_count            = r_count + SW'(1);
                    if (r_op != eoq_pkg::OP_SET_DROP) begin
                        n_head = SW'(free_idx);
                    end
                    n_res = res_order(eoq_pkg::STAT_DONE, SW'(free_idx), claim_ent);
                end
            end
            eoq_pkg::S_LINK: begin
                // Point the original order at its new copy.
                ram_we = 1'b1;
                ram_wa = r_h[IW-1:0];
                ram_wd = '{r_hent.pick, r_hent.dir, r_hent.drop, r_res.slot};
            end
            eoq_pkg::S_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= eoq_pkg::S_IDLE;
            r_head    <= NO_SLOT;
            r_count   <= '0;
            r_in_use  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_in_use  <= n_in_use;
            r_o_valid <= n_o_valid;
        end
    end

    // Operand, walk and result registers.
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_fl   <= n_fl;
        r_dir  <= n_dir;
        r_h    <= n_h;
        r_cur  <= n_cur;
        r_hent <= n_hent;
        r_res  <= n_res;
        if ((r_state == eoq_pkg::S_OUT) && out_free) begin
            r_o_status <= r_res.status;
            r_o_found  <= (r_res.slot != NO_SLOT);
            r_o_handle <= 5'(r_res.slot);
            r_o_pick   <= 3'(r_res.pick);
            r_o_dir    <= r_res.dir;
            r_o_drop   <= 3'(r_res.drop);
        end
    end

    assign o_in_stall      = (r_state != eoq_pkg::S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found         = r_o_found;
    assign o_result_handle = r_o_handle;
    assign o_res_pickup    = r_o_pick;
    assign o_res_dir       = r_o_dir;
    assign o_res_dropoff   = r_o_drop;

endmodule

// File: hw/rtl/eoq_checker.sv
`timescale 1ns / 1ps

module eoq_checker #(
    parameter int MAX_ORDERS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_opcode,
    input logic [2:0] i_floor,
    input logic [1:0] i_travel_dir,
    input logic [3:0] i_handle,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic       o_found,
    input logic [4:0] o_result_handle,
    input logic [2:0] o_res_pickup,
    input logic [1:0] o_res_dir,
    input logic [2:0] o_res_dropoff
);

    // A request that is held off stays offered and keeps its contents.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_opcode) && $stable(i_floor)
            && $stable(i_travel_dir) && $stable(i_handle))
        else $error("held request changed");

    // A result that is held back keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_found)
            && $stable(o_result_handle) && $stable(o_res_pickup) && $stable(o_res_dir)
            && $stable(o_res_dropoff))
        else $error("held result changed");

    // Only one request is in work at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while another is in work");

    // A result without an order shows the empty handle and zero fields.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_result_handle == 5'(MAX_ORDERS))
            && (o_res_pickup == 3'd0) && (o_res_dir == 2'd0) && (o_res_dropoff == 3'd0))
        else $error("empty result carries order data");

    // An order is only given with a done or duplicate status.
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> (o_status == eoq_pkg::STAT_DONE)
            || (o_status == eoq_pkg::STAT_DUP))
        else $error("order given with a failing status");

endmodule

bind elevator_order_queue_core eoq_checker #(
    .MAX_ORDERS(MAX_ORDERS)
) u_eoq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_opcode       (i_opcode),
    .i_floor        (i_floor),
    .i_travel_dir   (i_travel_dir),
    .i_handle       (i_handle),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_found        (o_found),
    .o_result_handle(o_result_handle),
    .o_res_pickup   (o_res_pickup),
    .o_res_dir      (o_res_dir),
    .o_res_dropoff  (o_res_dropoff)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ORDERS = 16;
    localparam int NUM_FLOORS = 4;
    localparam logic [4:0] NO_SLOT = 5'(MAX_ORDERS);
    localparam logic [2:0] UNKNOWN_FLOOR = 3'(NUM_FLOORS);

    localparam int RANDOM_ITEMS = 1900;
    localparam int BLOCK_ITEMS = 32;
    localparam int QUIET_ITEMS = 250;
    localparam int HOLD_OFF_AT = 400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;
    // The longest silence in a correct run is the long hold-off plus one full
    // list walk and the widest gaps on both sides; this is many times that.
    localparam int WATCHDOG_LIMIT = 2000;

    // One result of the order table, field by field.
    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [4:0] handle;
        logic [2:0] pickup;
        logic [1:0] dir;
        logic [2:0] dropoff;
    } t_order_reply;

    // Request mixes that push the table toward full, toward empty, or neither.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // Tracks the order list as the block should hold it and checks each
    // result against the oldest outstanding prediction.
    class order_table_checker;
        logic [2:0]   pickup_of  [MAX_ORDERS];
        logic [1:0]   dir_of     [MAX_ORDERS];
        logic [2:0]   dropoff_of [MAX_ORDERS];
        logic [4:0]   next_of    [MAX_ORDERS];
        bit           slot_used  [MAX_ORDERS];
        logic [4:0]   newest;
        t_order_reply expected_replies[$];
        int           mismatches;

        function new();
            for (int i = 0; i < MAX_ORDERS; i++) begin
                slot_used[i] = 1'b0;
                pickup_of[i] = '0;
                dir_of[i] = '0;
                dropoff_of[i] = '0;
                next_of[i] = NO_SLOT;
            end
            newest = NO_SLOT;
            mismatches = 0;
        endfunction

        // Searches run from the newest order to the oldest.
        function logic [4:0] newest_with_pickup(logic [2:0] fl, logic [1:0] dir);
            logic [4:0] s;
            s = newest;
            for (int n = 0; n < MAX_ORDERS && s != NO_SLOT; n++) begin
                if (pickup_of[s] == fl && dir_of[s] == dir)
                    return s;
                s = next_of[s];
            end
            return NO_SLOT;
        endfunction

        function logic [4:0] newest_with_dropoff(logic [2:0] fl);
            logic [4:0] s;
            s = newest;
            for (int n = 0; n < MAX_ORDERS && s != NO_SLOT; n++) begin
                if (dropoff_of[s] == fl)
                    return s;
                s = next_of[s];
            end
            return NO_SLOT;
        endfunction

        function logic [4:0] oldest_slot();
            logic [4:0] s;
            logic [4:0] last;
            s = newest;
            last = NO_SLOT;
            for (int n = 0; n < MAX_ORDERS && s != NO_SLOT; n++) begin
                last = s;
                s = next_of[s];
            end
            return last;
        endfunction

        // A new order always takes the lowest free slot.
        function logic [4:0] claim(logic [2:0] pk, logic [1:0] dr, logic [2:0] dp,
                                   logic [4:0] nx);
            for (int i = 0; i < MAX_ORDERS; i++) begin
                if (!slot_used[i]) begin
                    pickup_of[i] = pk;
                    dir_of[i] = dr;
                    dropoff_of[i] = dp;
                    next_of[i] = nx;
                    slot_used[i] = 1'b1;
                    return 5'(i);
                end
            end
            return NO_SLOT;
        endfunction

        function t_order_reply make_reply(eoq_pkg::t_status st, logic [4:0] s);
            t_order_reply r;
            r = '0;
            r.status = st;
            r.handle = NO_SLOT;
            if (s != NO_SLOT) begin
                r.found = 1'b1;
                r.handle = s;
                r.pickup = pickup_of[s];
                r.dir = dir_of[s];
                r.dropoff = dropoff_of[s];
            end
            return r;
        endfunction

        function logic [4:0] random_used_slot();
            logic [4:0] used_list[$];
            for (int i = 0; i < MAX_ORDERS; i++)
                if (slot_used[i])
                    used_list.push_back(5'(i));
            if (used_list.size() == 0)
                return NO_SLOT;
            return used_list[$urandom_range(used_list.size() - 1)];
        endfunction

        // Applies one accepted request to the list and queues its result.
        function void note_request(eoq_pkg::t_opcode op, logic [2:0] fl_in,
                                   logic [1:0] dir_in, logic [3:0] h);
            logic [2:0]   fl;
            logic [1:0]   dir;
            logic [4:0]   s;
            logic [4:0]   p;
            t_order_reply r;
            // Floors past the top and direction three both read as unknown.
            fl = (fl_in >= NUM_FLOORS) ? UNKNOWN_FLOOR : fl_in;
            dir = (dir_in > eoq_pkg::DIR_NONE) ? eoq_pkg::DIR_NONE : dir_in;
            case (op)
                eoq_pkg::OP_ADD_PICK: begin
                    s = newest_with_pickup(fl, dir);
                    if (s != NO_SLOT && dropoff_of[s] == UNKNOWN_FLOOR) begin
                        r = make_reply(eoq_pkg::STAT_DUP, s);
                    end else begin
                        s = claim(fl, dir, UNKNOWN_FLOOR, newest);
                        if (s == NO_SLOT) begin
                            r = make_reply(eoq_pkg::STAT_FULL, NO_SLOT);
                        end else begin
                            newest = s;
                            r = make_reply(eoq_pkg::STAT_DONE, s);
                        end
                    end
                end
                eoq_pkg::OP_ADD_DROP: begin
                    s = newest_with_dropoff(fl);
                    if (s != NO_SLOT) begin
                        r = make_reply(eoq_pkg::STAT_DUP, s);
                    end else begin
                        s = claim(UNKNOWN_FLOOR, eoq_pkg::DIR_NONE, fl, newest);
                        if (s == NO_SLOT) begin
                            r = make_reply(eoq_pkg::STAT_FULL, NO_SLOT);
                        end else begin
                            newest = s;
                            r = make_reply(eoq_pkg::STAT_DONE, s);
                        end
                    end
                end
                eoq_pkg::OP_OLDEST: begin
                    if (newest != NO_SLOT)
                        r = make_reply(eoq_pkg::STAT_DONE, oldest_slot());
                    else
                        r = make_reply(eoq_pkg::STAT_NONE, NO_SLOT);
                end
                eoq_pkg::OP_SET_DROP: begin
                    if (!slot_used[h]) begin
                        r = make_reply(eoq_pkg::STAT_BADH, NO_SLOT);
                    end else if (dropoff_of[h] == UNKNOWN_FLOOR) begin
                        dropoff_of[h] = fl;
                        r = make_reply(eoq_pkg::STAT_DONE, 5'(h));
                    end else begin
                        // A known drop-off gets a copy linked just behind the order.
                        s = claim(pickup_of[h], dir_of[h], fl, next_of[h]);
                        if (s == NO_SLOT) begin
                            r = make_reply(eoq_pkg::STAT_FULL, NO_SLOT);
                        end else begin
                            next_of[h] = s;
                            r = make_reply(eoq_pkg::STAT_DONE, s);
                        end
                    end
                end
                eoq_pkg::OP_REMOVE: begin
                    if (!slot_used[h]) begin
                        r = make_reply(eoq_pkg::STAT_BADH, NO_SLOT);
                    end else begin
                        if (newest == 5'(h)) begin
                            newest = next_of[h];
                        end else begin
                            p = newest;
                            for (int n = 0; n < MAX_ORDERS && p != NO_SLOT; n++) begin
                                if (next_of[p] == 5'(h)) begin
                                    next_of[p] = next_of[h];
                                    break;
                                end
                                p = next_of[p];
                            end
                        end
                        slot_used[h] = 1'b0;
                        r = make_reply(eoq_pkg::STAT_DONE, NO_SLOT);
                    end
                end
                eoq_pkg::OP_CLEAR: begin
                    for (int i = 0; i < MAX_ORDERS; i++)
                        slot_used[i] = 1'b0;
                    newest = NO_SLOT;
                    r = make_reply(eoq_pkg::STAT_DONE, NO_SLOT);
                end
                eoq_pkg::OP_FIND_PICK: begin
                    s = newest_with_pickup(fl, dir);
                    if (s != NO_SLOT)
                        r = make_reply(eoq_pkg::STAT_DONE, s);
                    else
                        r = make_reply(eoq_pkg::STAT_NONE, NO_SLOT);
                end
                default: begin
                    s = newest_with_dropoff(fl);
                    if (s != NO_SLOT)
                        r = make_reply(eoq_pkg::STAT_DONE, s);
                    else
                        r = make_reply(eoq_pkg::STAT_NONE, NO_SLOT);
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        function void note_mismatch(string what, t_order_reply want, t_order_reply got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s: expected st=%0d fd=%0d h=%0d pk=%0d dir=%0d dp=%0d,",
                         $time, what, want.status, want.found, want.handle, want.pickup,
                         want.dir, want.dropoff,
                         " got st=%0d fd=%0d h=%0d pk=%0d dir=%0d dp=%0d",
                         got.status, got.found, got.handle, got.pickup, got.dir,
                         got.dropoff);
        endfunction

        function void check_reply(logic [2:0] st, logic fd, logic [4:0] hd,
                                  logic [2:0] pk, logic [1:0] dr, logic [2:0] dp);
            t_order_reply got;
            t_order_reply want;
            got = '{st, fd, hd, pk, dr, dp};
            if (expected_replies.size() == 0) begin
                note_mismatch("result with no request outstanding", '0, got);
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.handle !== want.handle || got.pickup !== want.pickup ||
                got.dir !== want.dir || got.dropoff !== want.dropoff)
                note_mismatch("result mismatch", want, got);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_opcode = '0;
    logic [2:0] i_floor = '0;
    logic [1:0] i_travel_dir = '0;
    logic [3:0] i_handle = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [2:0] o_status;
    logic       o_found;
    logic [4:0] o_result_handle;
    logic [2:0] o_res_pickup;
    logic [1:0] o_res_dir;
    logic [2:0] o_res_dropoff;

    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    order_table_checker sb = new();

    elevator_order_queue_core #(
        .MAX_ORDERS(MAX_ORDERS),
        .NUM_FLOORS(NUM_FLOORS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_floor(i_floor),
        .i_travel_dir(i_travel_dir),
        .i_handle(i_handle),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_found(o_found),
        .o_result_handle(o_result_handle),
        .o_res_pickup(o_res_pickup),
        .o_res_dir(o_res_dir),
        .o_res_dropoff(o_res_dropoff)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offers one request from a falling edge and holds it until accepted.
    task automatic send_request(eoq_pkg::t_opcode op, logic [2:0] fl, logic [1:0] dir,
                                logic [3:0] h);
        int gap;
        if (idle_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_floor <= fl;
        i_travel_dir <= dir;
        i_handle <= h;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        sb.note_request(op, fl, dir, h);
        @(negedge i_clk);
    endtask

    task automatic send_random(t_mix mode);
        int               roll;
        eoq_pkg::t_opcode op;
        logic [2:0]       fl;
        logic [1:0]       dir;
        logic [3:0]       h;
        logic [4:0]       pick;
        roll = $urandom_range(99);
        case (mode)
            MIX_FILL:
                op = roll < 35 ? eoq_pkg::OP_ADD_PICK : roll < 55 ? eoq_pkg::OP_ADD_DROP :
                     roll < 75 ? eoq_pkg::OP_SET_DROP : roll < 80 ? eoq_pkg::OP_OLDEST :
                     roll < 86 ? eoq_pkg::OP_REMOVE : roll < 92 ? eoq_pkg::OP_FIND_PICK :
                     roll < 99 ? eoq_pkg::OP_FIND_DROP : eoq_pkg::OP_CLEAR;
            MIX_DRAIN:
                op = roll < 40 ? eoq_pkg::OP_REMOVE : roll < 50 ? eoq_pkg::OP_SET_DROP :
                     roll < 58 ? eoq_pkg::OP_ADD_PICK : roll < 64 ? eoq_pkg::OP_ADD_DROP :
                     roll < 74 ? eoq_pkg::OP_OLDEST : roll < 85 ? eoq_pkg::OP_FIND_PICK :
                     roll < 97 ? eoq_pkg::OP_FIND_DROP : eoq_pkg::OP_CLEAR;
            default:
                op = roll < 18 ? eoq_pkg::OP_ADD_PICK : roll < 30 ? eoq_pkg::OP_ADD_DROP :
                     roll < 45 ? eoq_pkg::OP_SET_DROP : roll < 60 ? eoq_pkg::OP_REMOVE :
                     roll < 70 ? eoq_pkg::OP_OLDEST : roll < 82 ? eoq_pkg::OP_FIND_PICK :
                     roll < 96 ? eoq_pkg::OP_FIND_DROP : eoq_pkg::OP_CLEAR;
        endcase
        // Mostly real floors and directions, sometimes the encodings above them.
        fl = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        dir = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        h = 4'($urandom_range(15));
        // Handle operations mostly target an order that exists.
        if ((op == eoq_pkg::OP_SET_DROP || op == eoq_pkg::OP_REMOVE) &&
            $urandom_range(99) < 85) begin
            pick = sb.random_used_slot();
            if (pick != NO_SLOT)
                h = pick[3:0];
        end
        send_request(op, fl, dir, h);
    endtask

    // Check every result taken from the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_reply(o_status, o_found, o_result_handle, o_res_pickup,
                           o_res_dir, o_res_dropoff);
    end

    // Result side back-pressure: short random bursts and one long hold-off.
    initial begin : result_stall
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(4) == 0) begin
                burst = $urandom_range(1, 7);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Ends the run if neither side moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("elevator_order_queue_core test failed");
        $finish;
    end

    initial begin : stimulus
        int   item_idx;
        t_mix mode;
        mode = MIX_FILL;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: nothing to get or find, and every handle is unused.
        send_request(eoq_pkg::OP_OLDEST, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_FIND_PICK, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_FIND_DROP, 3'd3, 2'd1, 4'd0);
        send_request(eoq_pkg::OP_REMOVE, 3'd0, 2'd0, 4'd5);
        send_request(eoq_pkg::OP_SET_DROP, 3'd1, 2'd0, 4'd15);
        // Pickup adds, a duplicate, and a pickup with unknown floor and direction.
        send_request(eoq_pkg::OP_ADD_PICK, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_ADD_PICK, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_ADD_PICK, 3'd7, 2'd3, 4'd0);
        send_request(eoq_pkg::OP_ADD_PICK, 3'd3, 2'd1, 4'd0);
        // Drop-off-only adds; an unknown drop-off matches the open pickups.
        send_request(eoq_pkg::OP_ADD_DROP, 3'd2, 2'd2, 4'd0);
        send_request(eoq_pkg::OP_ADD_DROP, 3'd2, 2'd2, 4'd0);
        send_request(eoq_pkg::OP_ADD_DROP, 3'd6, 2'd0, 4'd0);
        // Drop-off written in place, then a copy linked behind the order.
        send_request(eoq_pkg::OP_SET_DROP, 3'd3, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_SET_DROP, 3'd1, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_ADD_PICK, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_FIND_PICK, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_FIND_DROP, 3'd1, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_OLDEST, 3'd0, 2'd0, 4'd0);
        // Remove from the middle, the newest, and a slot already freed.
        send_request(eoq_pkg::OP_REMOVE, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_REMOVE, 3'd0, 2'd0, 4'd5);
        send_request(eoq_pkg::OP_REMOVE, 3'd0, 2'd0, 4'd5);
        send_request(eoq_pkg::OP_OLDEST, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_CLEAR, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_OLDEST, 3'd0, 2'd0, 4'd0);
        send_request(eoq_pkg::OP_ADD_DROP, 3'd7, 2'd3, 4'd15);

        // Random blocks each take a filling, draining or even mix, the first one filling.
        item_idx = 0;
        while (item_idx < RANDOM_ITEMS) begin
            if (item_idx % BLOCK_ITEMS == 0) begin
                mode = (item_idx == 0) ? MIX_FILL : t_mix'($urandom_range(2));
                idle_on = ($urandom_range(3) != 0);
            end
            if (item_idx >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (item_idx == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            send_random(mode);
            item_idx++;
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then give the block time to misbehave.
        while (sb.expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (MAX_ORDERS + 8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_replies.size() == 0)
            $display("elevator_order_queue_core test passed");
        else
            $display("elevator_order_queue_core test failed");
        $finish;
    end

endmodule

// File: elevator_order_queue_core.f
hw/rtl/eoq_pkg.sv
hw/rtl/eoq_entry_ram.sv
hw/rtl/elevator_order_queue_core.sv
hw/rtl/eoq_checker.sv
tb/sv/tb.sv
